// File: hdl/ptb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptb_pkg;

    localparam int TOKEN_W = 32;
    localparam int TIME_W  = 48;
    localparam int CFG_W   = 16;
    localparam logic [TOKEN_W-1:0] ONE_FX = 32'h0001_0000;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_PEEK    = 1'b1;

    typedef enum logic [1:0] {
        REG_LIMIT_ENABLED   = 2'd0,
        REG_BUCKET_CAPACITY = 2'd1,
        REG_WINDOW_SECONDS  = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [47:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } div_rsp_t;

endpackage

`default_nettype wire

// File: hdl/per_client_token_bucket.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | signals                                   | transfer
// in      | in_valid in_ready kind client_id now_ms   | in_valid & in_ready
// out     | out_valid out_ready allowed tokens_left    | out_valid & out_ready
//         | retry_after_s                              |
// cfg     | cfg_we cfg_index cfg_data                  | cfg_we
// One item at a time: read and decide, then the refill division if needed, then retry
// start and the retry division if needed; the shared 64-bit restoring divider serves
// both divisions. Reset clears the valid bits and the enable and sets capacity
// and window to 60; the tables need no clearing pass.
// in_ready is low from transfer until the result has been taken.
module per_client_token_bucket #(
    parameter int CLIENTS = 256
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [15:0]            cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   kind,
    input  wire logic [7:0]             client_id,
    input  wire logic [47:0]            now_ms,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        allowed,
    output logic [15:0]                 tokens_left,
    output logic [15:0]                 retry_after_s
);

    import ptb_pkg::*;

    localparam int AW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_LOAD, S_DECIDE, S_REFILL, S_RETRY, S_RWAIT, S_OUT
    } state_t;

    state_t state_reg;
    logic enabled_reg;
    logic [15:0] cap_reg, win_reg;
    logic [CLIENTS-1:0] valid_reg;

    logic kind_reg;
    logic [AW-1:0] idx_reg;
    logic [47:0] now_reg;
    logic [31:0] tok_reg;
    logic [47:0] elapsed_reg;
    logic entry_valid_reg;
    logic allowed_reg;
    logic [15:0] tokens_left_reg, retry_reg;

    logic [31:0] rd_tok;
    logic [47:0] rd_time;
    logic wr_en;
    logic [31:0] wr_tok;

    div_req_t dreq;
    div_rsp_t drsp;

    logic [AW-1:0] idx_in;
    logic [31:0] cap_fx;
    logic [47:0] span;
    logic [32:0] sum;
    logic [31:0] t_fill;
    logic [31:0] deficit;
    logic [47:0] num_retry;
    logic [63:0] q;
    logic        retry_div;

    assign idx_in  = AW'(client_id % CLIENTS);
    assign cap_fx  = {cap_reg, 16'h0};
    assign span    = 48'(win_reg) * 48'd1000;
    assign sum     = {1'b0, tok_reg} + {1'b0, drsp.quo[31:0]};
    assign deficit = ONE_FX - tok_reg;
    assign num_retry = 48'(deficit) * 48'(win_reg);
    assign q       = drsp.quo;
    assign retry_div = entry_valid_reg && (tok_reg < ONE_FX) && (win_reg != 16'd0)
                       && (cap_reg != 16'd0);

    ptb_ram #(.WIDTH(32), .DEPTH(CLIENTS)) u_tok (
        .clk(clk), .wr_en(wr_en), .wr_addr(idx_reg), .wr_data(wr_tok),
        .rd_addr(idx_reg), .rd_data(rd_tok)
    );

    ptb_ram #(.WIDTH(48), .DEPTH(CLIENTS)) u_time (
        .clk(clk), .wr_en(wr_en), .wr_addr(idx_reg), .wr_data(now_reg),
        .rd_addr(idx_reg), .rd_data(rd_time)
    );

    ptb_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_comb
    begin
        t_fill = (sum > {1'b0, cap_fx}) ? cap_fx : sum[31:0];
        wr_en  = 1'b0;
        wr_tok = tok_reg;
        dreq.start = 1'b0;
        dreq.num   = 64'(elapsed_reg) * 64'(cap_reg) << 16;
        dreq.den   = span;
        if (state_reg == S_DECIDE && kind_reg == KIND_REQUEST && enabled_reg)
        begin
            if (!entry_valid_reg || elapsed_reg >= span)
            begin
                wr_en = 1'b1;
                wr_tok = (cap_fx >= ONE_FX) ? cap_fx - ONE_FX : '0;
            end
            else
            begin
                dreq.start = 1'b1;
            end
        end
        else if (state_reg == S_REFILL && drsp.done)
        begin
            wr_en = 1'b1;
            wr_tok = (t_fill >= ONE_FX) ? t_fill - ONE_FX : '0;
        end
        else if (state_reg == S_RETRY && retry_div)
        begin
            dreq.start = 1'b1;
            dreq.num   = 64'(num_retry) + 64'({cap_reg, 16'h0}) - 64'd1;
            dreq.den   = 48'({cap_reg, 16'h0});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            enabled_reg <= 1'b0;
            cap_reg     <= 16'd60;
            win_reg     <= 16'd60;
            valid_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LIMIT_ENABLED:   enabled_reg <= cfg_data[0];
                    REG_BUCKET_CAPACITY: cap_reg <= cfg_data;
                    REG_WINDOW_SECONDS:  win_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ: state_reg <= S_LOAD;
                S_LOAD: state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    if (kind_reg == KIND_REQUEST && enabled_reg)
                    begin
                        valid_reg[idx_reg] <= 1'b1;
                        state_reg <= (!entry_valid_reg || elapsed_reg >= span)
                                     ? S_RETRY : S_REFILL;
                    end
                    else
                    begin
                        state_reg <= S_RETRY;
                    end
                end
                S_REFILL:
                begin
                    if (drsp.done)
                    begin
                        state_reg <= S_RETRY;
                    end
                end
                S_RETRY: state_reg <= retry_div ? S_RWAIT : S_OUT;
                S_RWAIT:
                begin
                    if (drsp.done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                kind_reg <= kind;
                idx_reg  <= idx_in;
                now_reg  <= now_ms;
                entry_valid_reg <= 1'b0;
                retry_reg <= '0;
            end
            S_READ:
            begin
                entry_valid_reg <= valid_reg[idx_reg];
            end
            S_LOAD:
            begin
                tok_reg     <= rd_tok;
                elapsed_reg <= (now_reg >= rd_time) ? now_reg - rd_time : '0;
            end
            S_DECIDE:
            begin
                allowed_reg <= 1'b1;
                if (kind_reg == KIND_REQUEST && enabled_reg)
                begin
                    if (!entry_valid_reg || elapsed_reg >= span)
                    begin
                        tok_reg <= (cap_fx >= ONE_FX) ? cap_fx - ONE_FX : '0;
                        allowed_reg <= (cap_fx >= ONE_FX);
                    end
                    entry_valid_reg <= 1'b1;
                end
                else if (kind_reg == KIND_PEEK && entry_valid_reg)
                begin
                    allowed_reg <= (tok_reg >= ONE_FX);
                end
            end
            S_REFILL:
            begin
                if (drsp.done)
                begin
                    tok_reg <= (t_fill >= ONE_FX) ? t_fill - ONE_FX : '0;
                    allowed_reg <= (t_fill >= ONE_FX);
                end
            end
            S_RETRY:
            begin
                tokens_left_reg <= entry_valid_reg ? tok_reg[31:16] : cap_reg;
                if (!retry_div)
                begin
                    retry_reg <= (entry_valid_reg && tok_reg < ONE_FX && win_reg != 16'd0
                                  && cap_reg == 16'd0) ? 16'hFFFF : 16'd0;
                end
            end
            S_RWAIT:
            begin
                if (drsp.done)
                begin
                    retry_reg <= (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
                end
            end
            default: ;
        endcase
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = (state_reg == S_OUT);
    assign allowed       = allowed_reg;
    assign tokens_left   = tokens_left_reg;
    assign retry_after_s = retry_reg;

endmodule

`default_nettype wire

// File: hdl/ptb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ptb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: hdl/ptb_div.sv
`timescale 1ns / 1ps
`default_nettype none

module ptb_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ptb_pkg::div_req_t  req,
    output ptb_pkg::div_rsp_t       rsp
);

    import ptb_pkg::*;

    logic [63:0] quo_reg, quo_next;
    logic [48:0] rem_reg, rem_next;
    logic [47:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [48:0] shifted;
    logic [48:0] diff;

    always_comb
    begin
        shifted   = {rem_reg[47:0], quo_reg[63]};
        diff      = shifted - {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[48])
            begin
                rem_next = diff;
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

`default_nettype wire

// File: dv/tb_per_client_token_bucket.sv
`timescale 1ns / 1ps

module tb_per_client_token_bucket;
    import ptb_pkg::*;

    localparam int NCLIENT   = 256;
    localparam int STALL_MAX = 200000;

    typedef struct packed {
        logic        allowed;
        logic [15:0] tokens_left;
        logic [15:0] retry_after_s;
    } decision_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = 1'b0;
    logic [7:0]  client_id = '0;
    logic [47:0] now_ms = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        allowed;
    logic [15:0] tokens_left;
    logic [15:0] retry_after_s;

    per_client_token_bucket dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .client_id(client_id), .now_ms(now_ms),
        .out_valid(out_valid), .out_ready(out_ready),
        .allowed(allowed), .tokens_left(tokens_left), .retry_after_s(retry_after_s)
    );

    always #6 clk = ~clk;

    logic        m_enabled;
    logic [15:0] m_capacity;
    logic [15:0] m_window;
    logic        m_seen [NCLIENT];
    logic [31:0] m_tokens [NCLIENT];
    logic [47:0] m_stamp [NCLIENT];

    decision_t   pending_decisions[$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_off = 1'b0;
    logic [47:0] clock_ms = 48'd1000;

    function automatic logic [15:0] retry_seconds(logic [31:0] fx);
        logic [63:0] deficit;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        if (fx >= ONE_FX)
            return 16'd0;
        deficit = 64'(ONE_FX - fx);
        num = deficit * 64'(m_window);
        if (num == 0)
            return 16'd0;
        if (m_capacity == 0)
            return 16'hFFFF;
        den = 64'(m_capacity) << 16;
        q = (num + den - 1) / den;
        return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
    endfunction

    function automatic decision_t bucket_decision(logic k, logic [7:0] id, logic [47:0] now);
        decision_t   d;
        logic [31:0] cap_fx;
        logic [63:0] span;
        logic [63:0] elapsed;
        logic [63:0] refill;
        logic [63:0] sum;
        logic [31:0] t;
        cap_fx = {m_capacity, 16'd0};
        if (k == KIND_REQUEST && m_enabled) begin
            span = 64'(m_window) * 64'd1000;
            if (!m_seen[id]) begin
                m_seen[id] = 1'b1;
                m_tokens[id] = cap_fx;
                m_stamp[id] = now;
            end
            elapsed = (now >= m_stamp[id]) ? 64'(now - m_stamp[id]) : 64'd0;
            if (elapsed >= span) begin
                t = cap_fx;
            end
            else begin
                refill = (elapsed * 64'(m_capacity) * 64'd65536) / span;
                sum = 64'(m_tokens[id]) + refill;
                t = (sum > 64'(cap_fx)) ? cap_fx : sum[31:0];
            end
            m_stamp[id] = now;
            if (t >= ONE_FX) begin
                t = t - ONE_FX;
                d.allowed = 1'b1;
            end
            else begin
                t = '0;
                d.allowed = 1'b0;
            end
            m_tokens[id] = t;
        end
        else if (k == KIND_REQUEST) begin
            d.allowed = 1'b1;
        end
        else begin
            d.allowed = m_seen[id] ? (m_tokens[id] >= ONE_FX) : 1'b1;
        end
        if (m_seen[id]) begin
            d.tokens_left = m_tokens[id][31:16];
            d.retry_after_s = retry_seconds(m_tokens[id]);
        end
        else begin
            d.tokens_left = m_capacity;
            d.retry_after_s = '0;
        end
        return d;
    endfunction

    task automatic write_reg(reg_index_t idx, logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LIMIT_ENABLED:   m_enabled = value[0];
            REG_BUCKET_CAPACITY: m_capacity = value;
            REG_WINDOW_SECONDS:  m_window = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic send_item(logic k, logic [7:0] id, logic [47:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        client_id <= id;
        now_ms <= now;
        @(posedge clk iff in_ready);
        pending_decisions.push_back(bucket_decision(k, id, now));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_idling(int s, int r);
        send_idle_pct = s;
        recv_stall_pct = r;
    endtask

    always @(posedge clk) begin
        if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        decision_t exp_d;
        if (out_valid && out_ready) begin
            if (pending_decisions.size() == 0) begin
                $display("%0t: unexpected result a=%0d t=%0d r=%0d",
                         $time, allowed, tokens_left, retry_after_s);
                errors++;
            end
            else begin
                exp_d = pending_decisions.pop_front();
                if (allowed !== exp_d.allowed) begin
                    $display("%0t: allowed expected %0d actual %0d",
                             $time, exp_d.allowed, allowed);
                    errors++;
                end
                if (tokens_left !== exp_d.tokens_left) begin
                    $display("%0t: tokens_left expected %0d actual %0d",
                             $time, exp_d.tokens_left, tokens_left);
                    errors++;
                end
                if (retry_after_s !== exp_d.retry_after_s) begin
                    $display("%0t: retry_after_s expected %0d actual %0d",
                             $time, exp_d.retry_after_s, retry_after_s);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic test_directed();
        write_reg(REG_LIMIT_ENABLED, 16'd0);
        send_item(KIND_REQUEST, 8'd0, 48'd0);
        send_item(KIND_PEEK, 8'd255, 48'hFFFF_FFFF_FFFF);
        drain();
        write_reg(REG_BUCKET_CAPACITY, 16'd2);
        write_reg(REG_WINDOW_SECONDS, 16'd3);
        write_reg(REG_LIMIT_ENABLED, 16'd1);
        send_item(KIND_REQUEST, 8'd7, 48'd1000);
        send_item(KIND_REQUEST, 8'd7, 48'd1000);
        send_item(KIND_REQUEST, 8'd7, 48'd1000);
        send_item(KIND_PEEK, 8'd7, 48'd1200);
        send_item(KIND_REQUEST, 8'd7, 48'd2000);
        send_item(KIND_REQUEST, 8'd7, 48'd500);
        send_item(KIND_REQUEST, 8'd7, 48'hFFFF_FFFF_FFFF);
        send_item(KIND_REQUEST, 8'd255, 48'hFFFF_FFFF_FFF0);
        send_item(KIND_PEEK, 8'd128, 48'd0);
        drain();
        write_reg(REG_BUCKET_CAPACITY, 16'd1);
        send_item(KIND_REQUEST, 8'd255, 48'hFFFF_FFFF_FFFF);
        drain();
        write_reg(REG_BUCKET_CAPACITY, 16'd65535);
        write_reg(REG_WINDOW_SECONDS, 16'd65535);
        send_item(KIND_REQUEST, 8'd42, 48'd0);
        send_item(KIND_REQUEST, 8'd42, 48'd1);
        drain();
        write_reg(REG_BUCKET_CAPACITY, 16'd0);
        send_item(KIND_REQUEST, 8'd3, 48'd10);
        send_item(KIND_PEEK, 8'd3, 48'd20);
        drain();
        write_reg(REG_WINDOW_SECONDS, 16'd0);
        write_reg(REG_BUCKET_CAPACITY, 16'd5);
        send_item(KIND_REQUEST, 8'd9, 48'd0);
        send_item(KIND_REQUEST, 8'd9, 48'd0);
        drain();
        write_reg(REG_LIMIT_ENABLED, 16'd0);
        send_item(KIND_REQUEST, 8'd9, 48'd5);
        drain();
    endtask

    task automatic random_burst(int n);
        logic [7:0]  id;
        logic [47:0] now;
        logic        k;
        repeat (n) begin
            id = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
            case ($urandom_range(9))
                0: now = 48'({$urandom, $urandom});
                1: now = clock_ms - 48'($urandom_range(5000));
                default:
                begin
                    clock_ms = clock_ms + 48'($urandom_range(3000));
                    now = clock_ms;
                end
            endcase
            k = ($urandom_range(4) == 0) ? KIND_PEEK : KIND_REQUEST;
            send_item(k, id, now);
        end
    endtask

    task automatic random_settings();
        write_reg(REG_LIMIT_ENABLED, 16'($urandom_range(9) != 0));
        case ($urandom_range(5))
            0: write_reg(REG_BUCKET_CAPACITY, 16'd65535);
            1: write_reg(REG_BUCKET_CAPACITY, 16'($urandom));
            default: write_reg(REG_BUCKET_CAPACITY, 16'($urandom_range(1, 8)));
        endcase
        case ($urandom_range(5))
            0: write_reg(REG_WINDOW_SECONDS, 16'd65535);
            1: write_reg(REG_WINDOW_SECONDS, 16'($urandom));
            default: write_reg(REG_WINDOW_SECONDS, 16'($urandom_range(1, 6)));
        endcase
    endtask

    task automatic test_idling_phases();
        set_idling(0, 0);
        random_settings();
        random_burst(110);
        drain();
        set_idling(63, 0);
        random_settings();
        random_burst(110);
        drain();
        set_idling(0, 63);
        random_settings();
        random_burst(110);
        drain();
        set_idling(6, 6);
        random_settings();
        random_burst(110);
        drain();
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        random_settings();
        fork
            begin
                hold_off = 1'b1;
                repeat (2000) @(posedge clk);
                hold_off = 1'b0;
            end
            random_burst(20);
        join
        drain();
        random_burst(10);
        drain();
        random_burst(10);
        drain();
    endtask

    initial begin
        for (int i = 0; i < NCLIENT; i++) begin
            m_seen[i] = 1'b0;
            m_tokens[i] = '0;
            m_stamp[i] = '0;
        end
        m_enabled = 1'b0;
        m_capacity = 16'd60;
        m_window = 16'd60;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_idling_phases();
        test_backpressure();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
